// ===== rtl/leb_pkg.sv =====
// leb_pkg: shared constants, key operation codes and queue item type
// for the line edit buffer. Depends on nothing; every rtl file imports it.
package leb_pkg;

    localparam int CAPACITY_DEF = 63;

    localparam int KEY_W     = 16;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 6;
    localparam int CFG_W     = 16;
    localparam int REG_N     = 7;
    localparam int REG_IDX_W = 3;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_BACKSPACE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DELETE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEFT      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HOME      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_END       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_REDRAW    = 3'd6;

    localparam logic [CFG_W-1:0] CFG_RESET [REG_N] = '{
        16'd8, 16'd127, 16'd61440, 16'd61441, 16'd61449, 16'd61450, 16'd65535
    };

    localparam logic [KEY_W-1:0] CTRL_CLEAR_KEY = 16'd117; // 'u'
    localparam logic [KEY_W-1:0] CTRL_BACK_KEY  = 16'd104; // 'h'
    localparam logic [KEY_W-1:0] PRINT_LOW      = 16'd32;
    localparam logic [KEY_W-1:0] PRINT_HIGH     = 16'd255;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_BACK,
        OP_DEL,
        OP_LEFT,
        OP_RIGHT,
        OP_HOME,
        OP_END,
        OP_REDRAW,
        OP_INSERT
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [CHAR_W-1:0]   ch;
    } key_op_t;

endpackage

// ===== rtl/line_edit_buffer.sv =====
// line_edit_buffer: top level of the single-line key-driven edit buffer.
// Depends on leb_pkg, leb_front, leb_queue and leb_back.
//
// Usage:
//  - Input channel (in_valid / in_stall): one transaction is one key press,
//    key_code plus control_held. in_stall rises only while the two-entry
//    operation queue is full, so keys are taken while the back end works.
//  - Output channel (out_valid / out_stall): each key gives one or more
//    result transactions. A key that edits the line or moves the cursor,
//    and a redraw, echoes the whole line, one character per transaction,
//    with last set on the final one; an empty line echoes once with
//    char_valid low. A refused or unknown key gives one transaction with
//    changed low.
//  - Configuration (cfg_write / cfg_index / cfg_data): seven 16-bit key
//    codes; the user must write them only while the block is idle, which
//    the block itself does not enforce. Index 7 is ignored.
//  - Timing: the back end pops and decodes a key in the same cycle. Insert
//    and delete then move the tail on the line store (one read, one write
//    port). The echo first primes the store read, then gives one result
//    per cycle while the receiver does not stall.
//  - Reset clears length, cursor, queue and output valid and restores the
//    default key codes; the line store itself is not cleared.
//  - When the receiver stalls, the result register holds its transaction
//    and the echo sequencer waits with the next character already read.
module line_edit_buffer
    import leb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // key input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KEY_W-1:0]     key_code,
    input  logic                 control_held,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 changed,
    output logic                 char_valid,
    output logic [CHAR_W-1:0]    char_value,
    output logic [POS_W-1:0]     char_index,
    output logic [POS_W-1:0]     line_length,
    output logic [POS_W-1:0]     cursor_at,
    output logic                 last
);

    logic    q_full;
    logic    q_not_empty;
    logic    q_push;
    logic    q_pop;
    key_op_t q_push_item;
    key_op_t q_head;

    // front end: key codes and classification
    leb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .key_code     (key_code),
        .control_held (control_held),
        .q_full       (q_full),
        .push         (q_push),
        .push_item    (q_push_item)
    );

    // decouples key intake from the edit and echo sequencer
    leb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back end: line store, cursor, shifting and echo
    leb_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .changed     (changed),
        .char_valid  (char_valid),
        .char_value  (char_value),
        .char_index  (char_index),
        .line_length (line_length),
        .cursor_at   (cursor_at),
        .last        (last)
    );

    assign in_stall = q_full;

endmodule

// ===== rtl/leb_front.sv =====
// leb_front: configuration registers and key classification.
// Depends on leb_pkg; feeds classified operations into leb_queue.
module leb_front
    import leb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic [KEY_W-1:0]     key_code,
    input  logic                 control_held,
    input  logic                 q_full,
    output logic                 push,
    output key_op_t              push_item
);

    logic [CFG_W-1:0] code_reg [REG_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_N; i++)
            begin
                code_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_write && (cfg_index < REG_IDX_W'(REG_N)))
        begin
            code_reg[cfg_index] <= cfg_data;
        end
    end

    // first match wins, control combos before configured codes
    always_comb
    begin
        push_item.ch   = key_code[CHAR_W-1:0];
        push_item.kind = OP_NONE;
        if (control_held && (key_code == CTRL_CLEAR_KEY))
            push_item.kind = OP_CLEAR;
        else if (control_held && (key_code == CTRL_BACK_KEY))
            push_item.kind = OP_BACK;
        else if (key_code == code_reg[REG_BACKSPACE])
            push_item.kind = OP_BACK;
        else if (key_code == code_reg[REG_DELETE])
            push_item.kind = OP_DEL;
        else if (key_code == code_reg[REG_LEFT])
            push_item.kind = OP_LEFT;
        else if (key_code == code_reg[REG_RIGHT])
            push_item.kind = OP_RIGHT;
        else if (key_code == code_reg[REG_HOME])
            push_item.kind = OP_HOME;
        else if (key_code == code_reg[REG_END])
            push_item.kind = OP_END;
        else if (key_code == code_reg[REG_REDRAW])
            push_item.kind = OP_REDRAW;
        else if ((key_code >= PRINT_LOW) && (key_code <= PRINT_HIGH))
            push_item.kind = OP_INSERT;
    end

    assign push = in_valid && !q_full;

endmodule

// ===== rtl/leb_queue.sv =====
// leb_queue: two-entry queue of classified key operations.
// Depends on leb_pkg for key_op_t; sits between leb_front and leb_back.
module leb_queue
    import leb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  key_op_t push_item,
    input  logic    pop,
    output logic    full,
    output logic    not_empty,
    output key_op_t head
);

    key_op_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/leb_back.sv =====
// leb_back: line store memory, fill count, cursor, shift sequencer and echo.
// Depends on leb_pkg; takes operations from leb_queue, drives the result port.
module leb_back
    import leb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  key_op_t           q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              changed,
    output logic              char_valid,
    output logic [CHAR_W-1:0] char_value,
    output logic [POS_W-1:0]  char_index,
    output logic [POS_W-1:0]  line_length,
    output logic [POS_W-1:0]  cursor_at,
    output logic              last
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SHIFT  = 4'b0010,
        ST_ECHO   = 4'b0100,
        ST_SINGLE = 4'b1000
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic              dir_ins_reg, dir_ins_next;   // 1: shift right for insert
    logic              more_reg, more_next;         // reads left in the shift
    logic              pend_reg, pend_next;         // read data waits to be written
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] stop_reg, stop_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0] ins_at_reg, ins_at_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [ADDR_W-1:0] em_reg, em_next;
    logic              data_ok_reg, data_ok_next;
    logic              chg_reg, chg_next;
    logic              simple_go;
    logic              simple_chg;
    logic              can_load;

    logic              out_valid_reg, out_valid_next;
    logic              chg_o_reg, chg_o_next;
    logic              cv_o_reg, cv_o_next;
    logic [CHAR_W-1:0] val_o_reg, val_o_next;
    logic [POS_W-1:0]  idx_o_reg, idx_o_next;
    logic [POS_W-1:0]  len_o_reg, len_o_next;
    logic [POS_W-1:0]  cur_o_reg, cur_o_next;
    logic              last_o_reg, last_o_next;

    logic [CHAR_W-1:0] mem [CAPACITY];
    logic [CHAR_W-1:0] rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CHAR_W-1:0] mem_wdata;

    assign can_load = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cur_next       = cur_reg;
        dir_ins_next   = dir_ins_reg;
        more_next      = more_reg;
        pend_next      = pend_reg;
        rd_ptr_next    = rd_ptr_reg;
        stop_next      = stop_reg;
        pend_addr_next = pend_addr_reg;
        ins_at_next    = ins_at_reg;
        ch_next        = ch_reg;
        em_next        = em_reg;
        data_ok_next   = data_ok_reg;
        chg_next       = chg_reg;
        simple_go      = 1'b0;
        simple_chg     = 1'b0;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = '0;

        out_valid_next = out_valid_reg && out_stall;
        chg_o_next     = chg_o_reg;
        cv_o_next      = cv_o_reg;
        val_o_next     = val_o_reg;
        idx_o_next     = idx_o_reg;
        len_o_next     = len_o_reg;
        cur_o_next     = cur_o_reg;
        last_o_next    = last_o_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.kind)
                        OP_CLEAR:
                        begin
                            fill_next  = '0;
                            cur_next   = '0;
                            simple_go  = 1'b1;
                            simple_chg = 1'b1;
                        end
                        OP_BACK:
                        begin
                            if ((cur_reg != '0) && (fill_reg != '0))
                            begin
                                // erase at cursor-1: pull cursor..fill-1 down
                                cur_next     = cur_reg - CNT_W'(1);
                                dir_ins_next = 1'b0;
                                more_next    = (cur_reg != fill_reg);
                                rd_ptr_next  = ADDR_W'(cur_reg);
                                stop_next    = ADDR_W'(fill_reg - CNT_W'(1));
                                pend_next    = 1'b0;
                                state_next   = ST_SHIFT;
                            end
                            else
                            begin
                                simple_go = 1'b1;
                            end
                        end
                        OP_DEL:
                        begin
                            if (cur_reg < fill_reg)
                            begin
                                dir_ins_next = 1'b0;
                                more_next    = ((cur_reg + CNT_W'(1)) != fill_reg);
                                rd_ptr_next  = ADDR_W'(cur_reg + CNT_W'(1));
                                stop_next    = ADDR_W'(fill_reg - CNT_W'(1));
                                pend_next    = 1'b0;
                                state_next   = ST_SHIFT;
                            end
                            else
                            begin
                                simple_go = 1'b1;
                            end
                        end
                        OP_LEFT:
                        begin
                            simple_go = 1'b1;
                            if (cur_reg != '0)
                            begin
                                cur_next   = cur_reg - CNT_W'(1);
                                simple_chg = 1'b1;
                            end
                        end
                        OP_RIGHT:
                        begin
                            simple_go = 1'b1;
                            if (cur_reg < fill_reg)
                            begin
                                cur_next   = cur_reg + CNT_W'(1);
                                simple_chg = 1'b1;
                            end
                        end
                        OP_HOME:
                        begin
                            simple_go = 1'b1;
                            if (cur_reg != '0)
                            begin
                                cur_next   = '0;
                                simple_chg = 1'b1;
                            end
                        end
                        OP_END:
                        begin
                            simple_go = 1'b1;
                            if (cur_reg < fill_reg)
                            begin
                                cur_next   = fill_reg;
                                simple_chg = 1'b1;
                            end
                        end
                        OP_REDRAW:
                        begin
                            simple_go  = 1'b1;
                            simple_chg = 1'b1;
                        end
                        OP_INSERT:
                        begin
                            if (fill_reg < CNT_W'(CAPACITY))
                            begin
                                // push cursor..fill-1 up one place, top first
                                dir_ins_next = 1'b1;
                                more_next    = (fill_reg != cur_reg);
                                rd_ptr_next  = ADDR_W'(fill_reg - CNT_W'(1));
                                stop_next    = ADDR_W'(cur_reg);
                                ins_at_next  = ADDR_W'(cur_reg);
                                ch_next      = q_head.ch;
                                pend_next    = 1'b0;
                                state_next   = ST_SHIFT;
                            end
                            else
                            begin
                                simple_go = 1'b1;
                            end
                        end
                        default:
                        begin
                            simple_go = 1'b1;
                        end
                    endcase

                    if (simple_go)
                    begin
                        chg_next     = simple_chg;
                        em_next      = '0;
                        data_ok_next = 1'b0;
                        if (simple_chg && (fill_next != '0))
                            state_next = ST_ECHO;
                        else
                            state_next = ST_SINGLE;
                    end
                end
            end

            ST_SHIFT:
            begin
                // one read and one write per cycle, the write one step behind
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dir_ins_reg ? (pend_addr_reg + ADDR_W'(1))
                                            : (pend_addr_reg - ADDR_W'(1));
                    mem_wdata = rd_data_reg;
                end
                if (more_reg)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = rd_ptr_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                    more_next      = (rd_ptr_reg != stop_reg);
                    rd_ptr_next    = dir_ins_reg ? (rd_ptr_reg - ADDR_W'(1))
                                                 : (rd_ptr_reg + ADDR_W'(1));
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        chg_next     = 1'b1;
                        em_next      = '0;
                        data_ok_next = 1'b0;
                        if (dir_ins_reg)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = ins_at_reg;
                            mem_wdata  = ch_reg;
                            fill_next  = fill_reg + CNT_W'(1);
                            cur_next   = cur_reg + CNT_W'(1);
                            state_next = ST_ECHO;
                        end
                        else
                        begin
                            fill_next = fill_reg - CNT_W'(1);
                            if (fill_reg == CNT_W'(1))
                                state_next = ST_SINGLE;
                            else
                                state_next = ST_ECHO;
                        end
                    end
                end
            end

            ST_ECHO:
            begin
                if (!data_ok_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = em_reg;
                    data_ok_next = 1'b1;
                end
                else if (can_load)
                begin
                    out_valid_next = 1'b1;
                    chg_o_next     = 1'b1;
                    cv_o_next      = 1'b1;
                    val_o_next     = rd_data_reg;
                    idx_o_next     = POS_W'(em_reg);
                    len_o_next     = POS_W'(fill_reg);
                    cur_o_next     = POS_W'(cur_reg);
                    last_o_next    = ((CNT_W'(em_reg) + CNT_W'(1)) == fill_reg);
                    if ((CNT_W'(em_reg) + CNT_W'(1)) == fill_reg)
                    begin
                        data_ok_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = em_reg + ADDR_W'(1);
                        em_next   = em_reg + ADDR_W'(1);
                    end
                end
            end

            ST_SINGLE:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    chg_o_next     = chg_reg;
                    cv_o_next      = 1'b0;
                    val_o_next     = '0;
                    idx_o_next     = '0;
                    len_o_next     = POS_W'(fill_reg);
                    cur_o_next     = POS_W'(cur_reg);
                    last_o_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        stop_reg      <= stop_next;
        pend_addr_reg <= pend_addr_next;
        ins_at_reg    <= ins_at_next;
        ch_reg        <= ch_next;
        em_reg        <= em_next;
        dir_ins_reg   <= dir_ins_next;
        chg_reg       <= chg_next;
        chg_o_reg     <= chg_o_next;
        cv_o_reg      <= cv_o_next;
        val_o_reg     <= val_o_next;
        idx_o_reg     <= idx_o_next;
        len_o_reg     <= len_o_next;
        cur_o_reg     <= cur_o_next;
        last_o_reg    <= last_o_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cur_reg       <= '0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            data_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cur_reg       <= cur_next;
            more_reg      <= more_next;
            pend_reg      <= pend_next;
            data_ok_reg   <= data_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign changed     = chg_o_reg;
    assign char_valid  = cv_o_reg;
    assign char_value  = val_o_reg;
    assign char_index  = idx_o_reg;
    assign line_length = len_o_reg;
    assign cursor_at   = cur_o_reg;
    assign last        = last_o_reg;

endmodule

// ===== verif/line_edit_buffer_tb.sv =====
// line_edit_buffer_tb: self-checking testbench for the line edit buffer.
// Depends on leb_pkg and line_edit_buffer; key presses go in, every echo
// transaction is checked against a cycle-free model of the edit line.
`timescale 1ns / 1ps

module line_edit_buffer_tb;
    import leb_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    // worst key: queue + decode + full tail move + full echo, plus margin
    localparam int SETTLE_CYCLES = 2 * CAPACITY_DEF + 10;
    localparam int HOLD_CYCLES   = 400;
    // index past the register list; the block must ignore writes to it
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic             ctrl;
    } key_item_t;

    typedef struct {
        logic              changed;
        logic              char_valid;
        logic [CHAR_W-1:0] char_value;
        logic [POS_W-1:0]  char_index;
        logic [POS_W-1:0]  line_length;
        logic [POS_W-1:0]  cursor_at;
        logic              last;
    } echo_t;

    // DUT connections; every input starts at a known value
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [KEY_W-1:0]     key_code     = '0;
    logic                 control_held = 1'b0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic                 changed;
    logic                 char_valid;
    logic [CHAR_W-1:0]    char_value;
    logic [POS_W-1:0]     char_index;
    logic [POS_W-1:0]     line_length;
    logic [POS_W-1:0]     cursor_at;
    logic                 last;

    // model state: line contents, length, cursor and configured key codes
    logic [CHAR_W-1:0] mdl_line [CAPACITY_DEF];
    int                mdl_len = 0;
    int                mdl_cur = 0;
    logic [CFG_W-1:0]  key_map  [REG_N];
    logic [CFG_W-1:0]  next_map [REG_N];

    key_item_t pending_keys [$];   // key presses not yet offered
    echo_t     expected_echo [$];  // echo transactions still to arrive

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_armed     = 1'b0;
    bit  hold_active    = 1'b0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;

    line_edit_buffer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_code     (key_code),
        .control_held (control_held),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .changed      (changed),
        .char_valid   (char_valid),
        .char_value   (char_value),
        .char_index   (char_index),
        .line_length  (line_length),
        .cursor_at    (cursor_at),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Edit-line model. Applies one accepted key press and queues the echo
    // transactions it should produce.
    // Control+u / control+h are decoded first, then the configured codes in
    // register order (first hit wins), then printable insertion.
    // ------------------------------------------------------------------
    task automatic predict_key_echo(input logic [KEY_W-1:0] key, input logic ctrl);
        op_kind_t op;
        bit       acted;
        echo_t    beat;
        int       i;
        op = OP_NONE;
        if (ctrl && key == CTRL_CLEAR_KEY)
            op = OP_CLEAR;
        else if (ctrl && key == CTRL_BACK_KEY)
            op = OP_BACK;
        else if (key == key_map[REG_BACKSPACE])
            op = OP_BACK;
        else if (key == key_map[REG_DELETE])
            op = OP_DEL;
        else if (key == key_map[REG_LEFT])
            op = OP_LEFT;
        else if (key == key_map[REG_RIGHT])
            op = OP_RIGHT;
        else if (key == key_map[REG_HOME])
            op = OP_HOME;
        else if (key == key_map[REG_END])
            op = OP_END;
        else if (key == key_map[REG_REDRAW])
            op = OP_REDRAW;
        else if (key >= PRINT_LOW && key <= PRINT_HIGH)
            op = OP_INSERT;

        acted = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                mdl_len = 0;
                mdl_cur = 0;
                acted   = 1'b1;
            end
            OP_BACK:
            begin
                // cursor never exceeds length, so cursor > 0 implies a char left of it
                if (mdl_cur > 0)
                begin
                    mdl_cur--;
                    for (i = mdl_cur; i < mdl_len - 1; i++)
                        mdl_line[i] = mdl_line[i + 1];
                    mdl_len--;
                    acted = 1'b1;
                end
            end
            OP_DEL:
            begin
                if (mdl_cur < mdl_len)
                begin
                    for (i = mdl_cur; i < mdl_len - 1; i++)
                        mdl_line[i] = mdl_line[i + 1];
                    mdl_len--;
                    acted = 1'b1;
                end
            end
            OP_LEFT:
            begin
                if (mdl_cur > 0)
                begin
                    mdl_cur--;
                    acted = 1'b1;
                end
            end
            OP_RIGHT:
            begin
                if (mdl_cur < mdl_len)
                begin
                    mdl_cur++;
                    acted = 1'b1;
                end
            end
            OP_HOME:
            begin
                if (mdl_cur > 0)
                begin
                    mdl_cur = 0;
                    acted   = 1'b1;
                end
            end
            OP_END:
            begin
                if (mdl_cur < mdl_len)
                begin
                    mdl_cur = mdl_len;
                    acted   = 1'b1;
                end
            end
            OP_REDRAW:
                acted = 1'b1;
            OP_INSERT:
            begin
                // full line refuses the insert
                if (mdl_len < CAPACITY_DEF)
                begin
                    for (i = mdl_len; i > mdl_cur; i--)
                        mdl_line[i] = mdl_line[i - 1];
                    mdl_line[mdl_cur] = key[CHAR_W-1:0];
                    mdl_cur++;
                    mdl_len++;
                    acted = 1'b1;
                end
            end
            default: ;
        endcase

        if (!acted)
        begin
            beat = '{1'b0, 1'b0, 8'd0, 6'd0, POS_W'(mdl_len), POS_W'(mdl_cur), 1'b1};
            expected_echo.push_back(beat);
        end
        else if (mdl_len == 0)
        begin
            // empty line still echoes once, with no character
            beat = '{1'b1, 1'b0, 8'd0, 6'd0, 6'd0, 6'd0, 1'b1};
            expected_echo.push_back(beat);
        end
        else
        begin
            for (i = 0; i < mdl_len; i++)
            begin
                beat = '{1'b1, 1'b1, mdl_line[i], POS_W'(i), POS_W'(mdl_len),
                         POS_W'(mdl_cur), (i == mdl_len - 1)};
                expected_echo.push_back(beat);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Key driver. A transaction completes on in_valid && !in_stall; the
    // model is stepped right then. A stalled key is held unchanged.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : key_driver
        key_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_key_echo(key_code, control_held);
            if (!in_valid || !in_stall)
            begin
                if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_keys.pop_front();
                    in_valid     <= 1'b1;
                    key_code     <= nxt.key;
                    control_held <= nxt.ctrl;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Echo monitor. Each completed output transaction is matched against
    // the oldest expectation; the receiver's stall is randomized here,
    // or forced high while the long hold-off runs.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : echo_monitor
        echo_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_echo.size() == 0)
                begin
                    $error("echo transaction with nothing expected: char_index %0d", char_index);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_echo.pop_front();
                    compare_field("changed",     want.changed,     changed);
                    compare_field("char_valid",  want.char_valid,  char_valid);
                    compare_field("char_value",  want.char_value,  char_value);
                    compare_field("char_index",  want.char_index,  char_index);
                    compare_field("line_length", want.line_length, line_length);
                    compare_field("cursor_at",   want.cursor_at,   cursor_at);
                    compare_field("last",        want.last,        last);
                end
            end
            out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // long receiver hold-off: lets the input queue fill and back-pressure
    initial
    begin : receiver_hold
        wait (hold_armed);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_key(input logic [KEY_W-1:0] key, input logic ctrl);
        key_item_t item;
        item.key  = key;
        item.ctrl = ctrl;
        pending_keys.push_back(item);
    endtask

    // mostly typing and editing keys, some control keys, some noise
    function automatic key_item_t random_key();
        key_item_t k;
        int        pick;
        pick   = $urandom_range(99);
        k.ctrl = ($urandom_range(7) == 0);
        if (pick < 45)
            k.key = KEY_W'($urandom_range(PRINT_HIGH, PRINT_LOW));
        else if (pick < 70)
            k.key = key_map[$urandom_range(REG_N - 1)];
        else if (pick < 75)
        begin
            k.key  = CTRL_CLEAR_KEY;
            k.ctrl = 1'b1;
        end
        else if (pick < 80)
        begin
            k.key  = CTRL_BACK_KEY;
            k.ctrl = 1'b1;
        end
        else if (pick < 90)
            k.key = KEY_W'($urandom);
        else if ($urandom_range(1))
            k.key = KEY_W'($urandom_range(PRINT_LOW - 1));
        else
            k.key = PRINT_HIGH + 1'b1;
        return k;
    endfunction

    // random keys with occasional typing bursts long enough to fill the line
    task automatic queue_random(input int n_items);
        int count;
        int burst;
        int j;
        count = 0;
        while (count < n_items)
        begin
            if ($urandom_range(11) == 0)
            begin
                burst = $urandom_range(66, 20);
                for (j = 0; j < burst; j++)
                    queue_key(KEY_W'($urandom_range(PRINT_HIGH, PRINT_LOW)), 1'b0);
                count += burst;
            end
            else
            begin
                pending_keys.push_back(random_key());
                count++;
            end
        end
    endtask

    // sample mid-cycle so all edge updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_keys.size() != 0 || in_valid || expected_echo.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes all seven key codes from next_map, then one ignored index
    task automatic load_key_map();
        int r;
        for (r = 0; r < REG_N; r++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= REG_IDX_W'(r);
            cfg_data  <= next_map[r];
            key_map[r] = next_map[r];
        end
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int r;
        for (r = 0; r < REG_N; r++)
            key_map[r] = CFG_RESET[r];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: reset key codes, no idling, directed keys first
        queue_key(key_map[REG_REDRAW], 1'b0);     // redraw of empty line
        queue_key(key_map[REG_BACKSPACE], 1'b0);  // refused edits on empty line
        queue_key(key_map[REG_DELETE], 1'b0);
        queue_key(key_map[REG_LEFT], 1'b0);
        queue_key(key_map[REG_RIGHT], 1'b0);
        queue_key(key_map[REG_HOME], 1'b0);
        queue_key(key_map[REG_END], 1'b0);
        queue_key(16'd0, 1'b0);                   // unknown keys
        queue_key(PRINT_LOW - 1'b1, 1'b0);
        queue_key(PRINT_HIGH + 1'b1, 1'b0);
        queue_key(PRINT_LOW, 1'b0);               // printable extremes
        queue_key(PRINT_HIGH, 1'b0);
        queue_key(16'd65, 1'b1);                  // control with plain key inserts
        queue_key(key_map[REG_LEFT], 1'b0);
        queue_key(key_map[REG_HOME], 1'b0);
        queue_key(16'd66, 1'b0);                  // insert at line start
        queue_key(key_map[REG_DELETE], 1'b0);
        queue_key(CTRL_BACK_KEY, 1'b1);           // control+h erases the char left of the cursor
        queue_key(key_map[REG_END], 1'b0);
        queue_key(key_map[REG_RIGHT], 1'b0);      // right at end refused
        queue_key(CTRL_BACK_KEY, 1'b1);
        queue_key(CTRL_CLEAR_KEY, 1'b0);          // plain 'u' and 'h' insert
        queue_key(CTRL_BACK_KEY, 1'b0);
        queue_key(CTRL_CLEAR_KEY, 1'b1);          // clear, then clear of empty line
        queue_key(CTRL_CLEAR_KEY, 1'b1);
        // fill the line past capacity so the last inserts are refused
        for (r = 0; r < CAPACITY_DEF + 3; r++)
            queue_key(KEY_W'($urandom_range(PRINT_HIGH, PRINT_LOW)), 1'b0);
        queue_random(55);
        hold_armed = 1'b1;   // receiver holds off while keys keep coming
        wait_drained();

        // phase 2: extreme codes, codes on 'u'/'h' and printables; sender idles
        next_map = '{16'd0, 16'hFFFF, PRINT_LOW, PRINT_HIGH,
                     CTRL_CLEAR_KEY, CTRL_BACK_KEY, 16'd1};
        load_key_map();
        send_idle_pct  = 81;
        recv_stall_pct = 0;
        queue_random(55);
        wait_drained();

        // phase 3: overlapping codes, first register in order wins; receiver stalls
        next_map = '{16'd97, 16'd97, 16'd97, 16'd98, 16'd98, 16'h8000, 16'h8000};
        load_key_map();
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        queue_random(55);
        wait_drained();

        // phase 4: random codes, half of them in the printable range
        for (r = 0; r < REG_N; r++)
            next_map[r] = $urandom_range(1) ? CFG_W'($urandom)
                                            : CFG_W'($urandom_range(PRINT_HIGH, PRINT_LOW));
        load_key_map();
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        queue_random(55);
        wait_drained();

        // phase 5: back to the default codes, no idling
        next_map = CFG_RESET;
        load_key_map();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(55);
        wait_drained();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/leb_pkg.sv
rtl/leb_front.sv
rtl/leb_queue.sv
rtl/leb_back.sv
rtl/line_edit_buffer.sv
verif/line_edit_buffer_tb.sv
